@@ rtl/core/qtt_pkg.sv @@
// Package with the shared types, codes and character classes of the query text tokenizer.
`default_nettype none
package qtt_pkg;

    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_OPER   = 3'd4;
    localparam logic [2:0] MODE_ERROR  = 3'd5;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] TYPE_IDENT  = 2'd0;
    localparam logic [1:0] TYPE_NUMBER = 2'd1;
    localparam logic [1:0] TYPE_STRING = 2'd2;
    localparam logic [1:0] TYPE_OPER   = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] ttype;
        logic [7:0] data;
        logic       tok_start;
        logic       tok_end;
    } t_result;

    typedef struct packed {
        logic [1:0]                  count;
        t_result [MAX_RES-1:0]       res;
    } t_bundle;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_cmp(input logic [7:0] c);
        return c inside {CH_LT, CH_GT, CH_BANG, CH_EQ};
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_LPAR, CH_RPAR, CH_COMMA};
    endfunction

    function automatic logic [1:0] held_type(input logic [2:0] mode);
        logic [1:0] t;
        case (mode)
            MODE_NUMBER: t = TYPE_NUMBER;
            MODE_STRING: t = TYPE_STRING;
            MODE_OPER:   t = TYPE_OPER;
            default:     t = TYPE_IDENT;
        endcase
        return t;
    endfunction

    function automatic t_result mk_res(input logic [1:0] kind, input logic [1:0] ttype,
                                       input logic [7:0] data, input logic s,
                                       input logic e);
        t_result r;
        r.kind      = kind;
        r.ttype     = ttype;
        r.data      = data;
        r.tok_start = s;
        r.tok_end   = e;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/qtt_front.sv @@
// Front end: accepts bytes, runs the scanner state and builds the results of each byte.
`default_nettype none
module qtt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_end_of_input,
    output qtt_pkg::t_bundle     o_bundle,
    output logic                 o_push
);

    logic [2:0] r_mode, n_mode;
    logic [7:0] r_hbyte, n_hbyte;
    logic       r_hval, n_hval;
    logic       r_hstart, n_hstart;

    qtt_pkg::t_result res4 [0:3];
    logic [1:0]       cnt;
    logic             do_start;
    logic             more;
    logic [1:0]       held_t;
    logic [7:0]       b;

    always_comb begin
        b        = i_in_byte;
        held_t   = qtt_pkg::held_type(r_mode);
        n_mode   = r_mode;
        n_hbyte  = r_hbyte;
        n_hval   = r_hval;
        n_hstart = r_hstart;
        cnt      = 2'd0;
        do_start = 1'b0;
        more     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            res4[i] = '0;
        end

        case (r_mode)
            qtt_pkg::MODE_IDENT, qtt_pkg::MODE_NUMBER: begin
                if (r_mode == qtt_pkg::MODE_NUMBER) begin
                    more = qtt_pkg::is_digit(b) || (b == qtt_pkg::CH_DOT);
                end else begin
                    more = qtt_pkg::is_alpha(b) || qtt_pkg::is_digit(b) ||
                           (b == qtt_pkg::CH_UNDER);
                end
                res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, held_t, r_hbyte,
                                            r_hstart, !more);
                cnt = cnt + 2'd1;
                if (more) begin
                    n_hbyte  = b;
                    n_hval   = 1'b1;
                    n_hstart = 1'b0;
                end else begin
                    n_mode   = qtt_pkg::MODE_IDLE;
                    n_hbyte  = '0;
                    n_hval   = 1'b0;
                    n_hstart = 1'b0;
                    do_start = 1'b1;
                end
            end
            qtt_pkg::MODE_STRING: begin
                if (b == qtt_pkg::CH_QUOTE) begin
                    if (r_hval) begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_STRING,
                                                    r_hbyte, r_hstart, 1'b1);
                    end else begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_EMPTY, qtt_pkg::TYPE_STRING,
                                                    8'd0, 1'b1, 1'b1);
                    end
                    cnt      = cnt + 2'd1;
                    n_mode   = qtt_pkg::MODE_IDLE;
                    n_hbyte  = '0;
                    n_hval   = 1'b0;
                    n_hstart = 1'b0;
                end else if (r_hval) begin
                    res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_STRING,
                                                r_hbyte, r_hstart, 1'b0);
                    cnt      = cnt + 2'd1;
                    n_hbyte  = b;
                    n_hstart = 1'b0;
                end else begin
                    n_hbyte  = b;
                    n_hval   = 1'b1;
                    n_hstart = 1'b1;
                end
            end
            qtt_pkg::MODE_OPER: begin
                n_mode   = qtt_pkg::MODE_IDLE;
                n_hbyte  = '0;
                n_hval   = 1'b0;
                n_hstart = 1'b0;
                if (b == qtt_pkg::CH_EQ) begin
                    res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER,
                                                r_hbyte, 1'b1, 1'b0);
                    cnt = cnt + 2'd1;
                    res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER,
                                                b, 1'b0, 1'b1);
                    cnt = cnt + 2'd1;
                end else if (r_hbyte == qtt_pkg::CH_BANG) begin
                    res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_ERROR, qtt_pkg::TYPE_IDENT,
                                                r_hbyte, 1'b0, 1'b0);
                    cnt    = cnt + 2'd1;
                    n_mode = qtt_pkg::MODE_ERROR;
                end else begin
                    res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER,
                                                r_hbyte, 1'b1, 1'b1);
                    cnt      = cnt + 2'd1;
                    do_start = 1'b1;
                end
            end
            qtt_pkg::MODE_ERROR: begin
            end
            default: begin
                n_mode   = qtt_pkg::MODE_IDLE;
                n_hbyte  = '0;
                n_hval   = 1'b0;
                n_hstart = 1'b0;
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            if (qtt_pkg::is_space(b)) begin
            end else if (b == qtt_pkg::CH_QUOTE) begin
                n_mode = qtt_pkg::MODE_STRING;
            end else if (qtt_pkg::is_cmp(b)) begin
                n_mode   = qtt_pkg::MODE_OPER;
                n_hbyte  = b;
                n_hval   = 1'b1;
                n_hstart = 1'b1;
            end else if (qtt_pkg::is_single_op(b)) begin
                res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER,
                                            b, 1'b1, 1'b1);
                cnt = cnt + 2'd1;
            end else if (qtt_pkg::is_digit(b)) begin
                n_mode   = qtt_pkg::MODE_NUMBER;
                n_hbyte  = b;
                n_hval   = 1'b1;
                n_hstart = 1'b1;
            end else if (qtt_pkg::is_alpha(b) || (b == qtt_pkg::CH_UNDER)) begin
                n_mode   = qtt_pkg::MODE_IDENT;
                n_hbyte  = b;
                n_hval   = 1'b1;
                n_hstart = 1'b1;
            end else begin
                res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_ERROR, qtt_pkg::TYPE_IDENT,
                                            b, 1'b0, 1'b0);
                cnt    = cnt + 2'd1;
                n_mode = qtt_pkg::MODE_ERROR;
            end
        end

        if (i_end_of_input) begin
            case (n_mode)
                qtt_pkg::MODE_IDENT, qtt_pkg::MODE_NUMBER, qtt_pkg::MODE_STRING: begin
                    if (n_hval) begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE,
                                                    qtt_pkg::held_type(n_mode),
                                                    n_hbyte, n_hstart, 1'b1);
                        cnt = cnt + 2'd1;
                    end else if (n_mode == qtt_pkg::MODE_STRING) begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_EMPTY, qtt_pkg::TYPE_STRING,
                                                    8'd0, 1'b1, 1'b1);
                        cnt = cnt + 2'd1;
                    end
                end
                qtt_pkg::MODE_OPER: begin
                    if (n_hbyte == qtt_pkg::CH_BANG) begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_ERROR, qtt_pkg::TYPE_IDENT,
                                                    n_hbyte, 1'b0, 1'b0);
                    end else begin
                        res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER,
                                                    n_hbyte, 1'b1, 1'b1);
                    end
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            res4[cnt] = qtt_pkg::mk_res(qtt_pkg::KIND_END, qtt_pkg::TYPE_IDENT,
                                        8'd0, 1'b0, 1'b0);
            cnt      = cnt + 2'd1;
            n_mode   = qtt_pkg::MODE_IDLE;
            n_hbyte  = '0;
            n_hval   = 1'b0;
            n_hstart = 1'b0;
        end
    end

    always_comb begin
        o_bundle.count = cnt;
        for (int i = 0; i < qtt_pkg::MAX_RES; i++) begin
            o_bundle.res[i] = res4[i];
        end
    end

    assign o_push = i_accept && (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= qtt_pkg::MODE_IDLE;
            r_hbyte  <= '0;
            r_hval   <= 1'b0;
            r_hstart <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_hbyte  <= n_hbyte;
            r_hval   <= n_hval;
            r_hstart <= n_hstart;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/qtt_fifo.sv @@
// Short queue of per-byte result groups between the scanner and the output stage.
`default_nettype none
module qtt_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire qtt_pkg::t_bundle  i_wdata,
    input  wire logic              i_rd,
    output qtt_pkg::t_bundle       o_rdata,
    output logic                   o_full,
    output logic                   o_nempty
);

    qtt_pkg::t_bundle                 r_mem [qtt_pkg::FIFO_DEPTH];
    logic [qtt_pkg::FIFO_AW-1:0]      r_wptr, r_rptr;
    logic [qtt_pkg::FIFO_AW:0]        r_count, n_count;

    assign o_full   = (r_count == (qtt_pkg::FIFO_AW+1)'(qtt_pkg::FIFO_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_rdata  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !(i_rd && o_nempty)) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd && o_nempty) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd && o_nempty) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/qtt_back.sv @@
// Output stage: holds one result group and hands its words out one per pop.
`default_nettype none
module qtt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_nempty,
    input  wire qtt_pkg::t_bundle  i_q_data,
    output logic                   o_q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output logic [1:0]             o_kind,
    output logic [1:0]             o_token_type,
    output logic [7:0]             o_out_byte,
    output logic                   o_token_start,
    output logic                   o_token_end,
    output logic                   o_run_end
);

    logic             r_valid;
    qtt_pkg::t_bundle r_bundle;
    logic [1:0]       r_idx;
    logic             last_word;
    logic             load;
    qtt_pkg::t_result cur;

    assign cur       = r_bundle.res[r_idx];
    assign last_word = (r_idx == (r_bundle.count - 2'd1));
    assign load      = i_q_nempty && (!r_valid || (pop && last_word));
    assign o_q_rd    = load;

    assign empty         = !r_valid;
    assign o_kind        = cur.kind;
    assign o_token_type  = cur.ttype;
    assign o_out_byte    = cur.data;
    assign o_token_start = cur.tok_start;
    assign o_token_end   = cur.tok_end;
    assign o_run_end     = last_word;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && pop) begin
            if (last_word) begin
                r_valid <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/query_text_tokenizer.sv @@
// Top level of the query text tokenizer: scanner, result queue and output stage.
// A byte's results are written to the queue, then loaded into the output stage.
// Throughput: one byte per cycle in while the queue is not full; one result word per
// cycle out while pop is held, and the four-entry queue absorbs bursts.
// Reset is synchronous and active low; it clears the scanner state, the queue and the
// output stage, and the block takes bytes in the first cycle after reset.
`default_nettype none
module query_text_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_input,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_token_type,
    output logic [7:0]       o_out_byte,
    output logic             o_token_start,
    output logic             o_token_end,
    output logic             o_run_end
);

    qtt_pkg::t_bundle wr_bundle;
    qtt_pkg::t_bundle rd_bundle;
    logic             q_push;
    logic             q_rd;
    logic             q_nempty;
    logic             accept;

    assign accept = push && !full;

    qtt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_bundle       (wr_bundle),
        .o_push         (q_push)
    );

    qtt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_push),
        .i_wdata  (wr_bundle),
        .i_rd     (q_rd),
        .o_rdata  (rd_bundle),
        .o_full   (full),
        .o_nempty (q_nempty)
    );

    qtt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nempty    (q_nempty),
        .i_q_data      (rd_bundle),
        .o_q_rd        (q_rd),
        .pop           (pop),
        .empty         (empty),
        .o_kind        (o_kind),
        .o_token_type  (o_token_type),
        .o_out_byte    (o_out_byte),
        .o_token_start (o_token_start),
        .o_token_end   (o_token_end),
        .o_run_end     (o_run_end)
    );

endmodule
`default_nettype wire

@@ rtl/core/qtt_checker.sv @@
// Port-level checker for the query text tokenizer and its bind to the top level.
`default_nettype none
module qtt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] o_kind,
    input wire logic [1:0] o_token_type,
    input wire logic       o_token_start,
    input wire logic       o_token_end,
    input wire logic       o_run_end
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_run_end)))
        else $error("waiting word changed before pop");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == qtt_pkg::KIND_END)) |-> o_run_end)
        else $error("end token is not the last word of its byte");

    a_empty_str: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == qtt_pkg::KIND_EMPTY)) |->
        (o_token_start && o_token_end && (o_token_type == qtt_pkg::TYPE_STRING)))
        else $error("empty string token has wrong marks");

    a_error_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == qtt_pkg::KIND_ERROR)) |->
        (!o_token_start && !o_token_end && (o_token_type == qtt_pkg::TYPE_IDENT)))
        else $error("error word carries token marks");

endmodule

bind query_text_tokenizer qtt_checker u_qtt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_token_type  (o_token_type),
    .o_token_start (o_token_start),
    .o_token_end   (o_token_end),
    .o_run_end     (o_run_end)
);
`default_nettype wire

@@ test/query_text_tokenizer_tb.sv @@
// Self-checking testbench for the query text tokenizer: queued stimulus, in-line predictor.
`timescale 1ns / 1ps

module query_text_tokenizer_tb;

    localparam logic [1:0] NO_TYPE = 2'd0;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 410;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        logic       drain;
    } t_text_byte;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] ttype;
        logic [7:0] data;
        logic       first;
        logic       close;
        logic       last;
    } t_tok_word;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_kind;
    logic [1:0] o_token_type;
    logic [7:0] o_out_byte;
    logic       o_token_start;
    logic       o_token_end;
    logic       o_run_end;

    t_text_byte pending_bytes[$];
    logic [7:0] text_buf[$];
    t_tok_word  step_words[$];
    t_tok_word  expected_words[$];
    t_tok_word  want_word;

    logic [2:0] scan_state = qtt_pkg::MODE_IDLE;
    logic [7:0] held_char = 8'h00;
    logic       held_ok = 1'b0;
    logic       held_first = 1'b0;

    int bytes_taken = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    logic calm;

    assign calm = (bytes_taken >= 150) && (bytes_taken < 260);

    query_text_tokenizer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_token_type   (o_token_type),
        .o_out_byte     (o_out_byte),
        .o_token_start  (o_token_start),
        .o_token_end    (o_token_end),
        .o_run_end      (o_run_end)
    );

    function automatic logic ws_char(input logic [7:0] c);
        return (c == qtt_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= qtt_pkg::CH_ZERO) && (c <= qtt_pkg::CH_NINE);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [1:0] type_of_mode(input logic [2:0] m);
        if (m == qtt_pkg::MODE_NUMBER) return qtt_pkg::TYPE_NUMBER;
        if (m == qtt_pkg::MODE_STRING) return qtt_pkg::TYPE_STRING;
        if (m == qtt_pkg::MODE_OPER) return qtt_pkg::TYPE_OPER;
        return qtt_pkg::TYPE_IDENT;
    endfunction

    task automatic add_word(input logic [1:0] k, input logic [1:0] t, input logic [7:0] d,
                            input logic s, input logic e);
        t_tok_word w;
        w.kind = k;
        w.ttype = t;
        w.data = d;
        w.first = s;
        w.close = e;
        w.last = 1'b0;
        step_words.insert(step_words.size(), w);
    endtask

    task automatic put_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic clear_held();
        scan_state = qtt_pkg::MODE_IDLE;
        held_char = 8'h00;
        held_ok = 1'b0;
        held_first = 1'b0;
    endtask

    task automatic keep_char(input logic [2:0] m, input logic [7:0] c, input logic s);
        scan_state = m;
        held_char = c;
        held_ok = 1'b1;
        held_first = s;
    endtask

    task automatic open_token(input logic [7:0] c);
        if (ws_char(c)) begin
            return;
        end
        if (c == qtt_pkg::CH_QUOTE) begin
            clear_held();
            scan_state = qtt_pkg::MODE_STRING;
        end else if (c == qtt_pkg::CH_LT || c == qtt_pkg::CH_GT || c == qtt_pkg::CH_BANG
                     || c == qtt_pkg::CH_EQ) begin
            keep_char(qtt_pkg::MODE_OPER, c, 1'b1);
        end else if (c == qtt_pkg::CH_PLUS || c == qtt_pkg::CH_MINUS || c == qtt_pkg::CH_STAR
                     || c == qtt_pkg::CH_LPAR || c == qtt_pkg::CH_RPAR
                     || c == qtt_pkg::CH_COMMA) begin
            add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER, c, 1'b1, 1'b1);
        end else if (digit_char(c)) begin
            keep_char(qtt_pkg::MODE_NUMBER, c, 1'b1);
        end else if (letter_char(c) || c == qtt_pkg::CH_UNDER) begin
            keep_char(qtt_pkg::MODE_IDENT, c, 1'b1);
        end else begin
            add_word(qtt_pkg::KIND_ERROR, NO_TYPE, c, 1'b0, 1'b0);
            clear_held();
            scan_state = qtt_pkg::MODE_ERROR;
        end
    endtask

    // Works out the words that one accepted byte causes and queues them.
    task automatic predict_byte(input logic [7:0] b, input logic eoi);
        logic [1:0] t;
        logic       s;
        logic       more;
        t = type_of_mode(scan_state);
        s = held_first;
        case (scan_state)
            qtt_pkg::MODE_IDENT, qtt_pkg::MODE_NUMBER: begin
                if (scan_state == qtt_pkg::MODE_NUMBER) begin
                    more = digit_char(b) || b == qtt_pkg::CH_DOT;
                end else begin
                    more = letter_char(b) || digit_char(b) || b == qtt_pkg::CH_UNDER;
                end
                if (more) begin
                    add_word(qtt_pkg::KIND_BYTE, t, held_char, s, 1'b0);
                    keep_char(scan_state, b, 1'b0);
                end else begin
                    add_word(qtt_pkg::KIND_BYTE, t, held_char, s, 1'b1);
                    clear_held();
                    open_token(b);
                end
            end
            qtt_pkg::MODE_STRING: begin
                if (b == qtt_pkg::CH_QUOTE) begin
                    if (held_ok) begin
                        add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_STRING, held_char, s, 1'b1);
                    end else begin
                        add_word(qtt_pkg::KIND_EMPTY, qtt_pkg::TYPE_STRING, 8'h00, 1'b1, 1'b1);
                    end
                    clear_held();
                end else if (held_ok) begin
                    add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_STRING, held_char, s, 1'b0);
                    keep_char(qtt_pkg::MODE_STRING, b, 1'b0);
                end else begin
                    keep_char(qtt_pkg::MODE_STRING, b, 1'b1);
                end
            end
            qtt_pkg::MODE_OPER: begin
                if (b == qtt_pkg::CH_EQ) begin
                    add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER, held_char, 1'b1, 1'b0);
                    add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER, b, 1'b0, 1'b1);
                    clear_held();
                end else if (held_char == qtt_pkg::CH_BANG) begin
                    add_word(qtt_pkg::KIND_ERROR, NO_TYPE, held_char, 1'b0, 1'b0);
                    clear_held();
                    scan_state = qtt_pkg::MODE_ERROR;
                end else begin
                    add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER, held_char, 1'b1, 1'b1);
                    clear_held();
                    open_token(b);
                end
            end
            qtt_pkg::MODE_ERROR: begin
            end
            default: begin
                clear_held();
                open_token(b);
            end
        endcase
        if (eoi) begin
            case (scan_state)
                qtt_pkg::MODE_IDENT, qtt_pkg::MODE_NUMBER, qtt_pkg::MODE_STRING: begin
                    if (held_ok) begin
                        add_word(qtt_pkg::KIND_BYTE, type_of_mode(scan_state), held_char,
                                 held_first, 1'b1);
                    end else if (scan_state == qtt_pkg::MODE_STRING) begin
                        add_word(qtt_pkg::KIND_EMPTY, qtt_pkg::TYPE_STRING, 8'h00, 1'b1, 1'b1);
                    end
                end
                qtt_pkg::MODE_OPER: begin
                    if (held_char == qtt_pkg::CH_BANG) begin
                        add_word(qtt_pkg::KIND_ERROR, NO_TYPE, held_char, 1'b0, 1'b0);
                    end else begin
                        add_word(qtt_pkg::KIND_BYTE, qtt_pkg::TYPE_OPER, held_char, 1'b1, 1'b1);
                    end
                end
                default: begin
                end
            endcase
            add_word(qtt_pkg::KIND_END, NO_TYPE, 8'h00, 1'b0, 1'b0);
            clear_held();
        end
        if (step_words.size() != 0) begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        while (step_words.size() != 0) begin
            expected_words.insert(expected_words.size(), step_words.pop_front());
        end
    endtask

    task automatic add_chars(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endtask

    // Moves the buffered text into the send queue, marking its last byte as end of input.
    task automatic queue_text(input logic drain);
        t_text_byte tb;
        for (int i = 0; i < text_buf.size(); i++) begin
            tb.ch = text_buf[i];
            tb.eoi = (i == text_buf.size() - 1);
            tb.drain = drain && (i == 0);
            pending_bytes.insert(pending_bytes.size(), tb);
        end
        text_buf.delete();
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_byte(i_in_byte, i_end_of_input);
                bytes_taken <= bytes_taken + 1;
            end
            if (!push || !full) begin
                if (pending_bytes.size() != 0
                    && !(pending_bytes[0].drain && expected_words.size() != 0)
                    && (calm || $urandom_range(99) >= 13)) begin
                    push <= 1'b1;
                    i_in_byte <= pending_bytes[0].ch;
                    i_end_of_input <= pending_bytes[0].eoi;
                    void'(pending_bytes.pop_front());
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: word expected none, actual kind %0d type %0d byte %0h",
                             $time, o_kind, o_token_type, o_out_byte);
                end else begin
                    want_word = expected_words.pop_front();
                    report_field("kind", want_word.kind, o_kind);
                    report_field("token_type", want_word.ttype, o_token_type);
                    report_field("out_byte", want_word.data, o_out_byte);
                    report_field("token_start", want_word.first, o_token_start);
                    report_field("token_end", want_word.close, o_token_end);
                    report_field("run_end", want_word.last, o_run_end);
                end
            end
            pop <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int         total;
        int         queries;
        int         len;
        logic [7:0] c;
        string      letters;
        string      op_chars;
        string      cmp_chars;

        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        op_chars = "+-*(),<>=";
        cmp_chars = "<>!=";

        add_chars("a9<=1.2,'q''");
        queue_text(1'b0);
        add_chars("!=''!x(");
        queue_text(1'b0);
        add_chars("=!");
        queue_text(1'b1);
        add_chars("x.");
        put_char(8'hFF);
        put_char(8'h00);
        queue_text(1'b0);
        add_chars("'a");
        queue_text(1'b0);

        total = 0;
        queries = 0;
        while (total < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        put_char(($urandom_range(0, 7) == 0) ? qtt_pkg::CH_UNDER
                                 : letters[$urandom_range(0, 51)]);
                        repeat ($urandom_range(0, 4)) begin
                            put_char(letters[$urandom_range(0, 62)]);
                        end
                    end
                    5, 6, 7: begin
                        put_char(letters[52 + $urandom_range(0, 9)]);
                        repeat ($urandom_range(0, 3)) begin
                            put_char(($urandom_range(0, 3) == 0) ? qtt_pkg::CH_DOT
                                     : letters[52 + $urandom_range(0, 9)]);
                        end
                    end
                    8, 9, 10: begin
                        put_char(qtt_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 5)) begin
                            c = 8'($urandom_range(0, 255));
                            put_char(c);
                        end
                        if ($urandom_range(0, 4) != 0) begin
                            put_char(qtt_pkg::CH_QUOTE);
                        end
                    end
                    11, 12, 13: begin
                        put_char(op_chars[$urandom_range(0, 8)]);
                    end
                    14, 15: begin
                        put_char(cmp_chars[$urandom_range(0, 3)]);
                        put_char(qtt_pkg::CH_EQ);
                    end
                    16: begin
                        repeat ($urandom_range(1, 3)) begin
                            c = ($urandom_range(0, 5) == 5) ? qtt_pkg::CH_SPACE
                                : 8'($urandom_range(9, 13));
                            put_char(c);
                        end
                    end
                    17: begin
                        put_char(qtt_pkg::CH_QUOTE);
                        put_char(qtt_pkg::CH_QUOTE);
                    end
                    18: begin
                        c = 8'($urandom_range(0, 255));
                        put_char(c);
                    end
                    default: begin
                        put_char(qtt_pkg::CH_BANG);
                    end
                endcase
                if ($urandom_range(0, 9) < 4) begin
                    put_char(qtt_pkg::CH_SPACE);
                end
            end
            len = text_buf.size();
            total += len;
            queries++;
            queue_text(queries % 15 == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || push) begin
            @(negedge i_clk);
        end
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ query_text_tokenizer.f @@
rtl/core/qtt_pkg.sv
rtl/core/qtt_front.sv
rtl/core/qtt_fifo.sv
rtl/core/qtt_back.sv
rtl/core/query_text_tokenizer.sv
rtl/core/qtt_checker.sv
test/query_text_tokenizer_tb.sv
